/* sv/ddts_pkg.sv */
// ----------------------------------------------------------------------------
// ddts_pkg: shared types and constants of the device descriptor table search
// Request codes, result status codes, the sequencer states and the field
// constants used when entries are stored and compared.
// ----------------------------------------------------------------------------
package ddts_pkg;

  // Request codes carried by req_type.
  localparam logic [2:0] REQ_INSERT        = 3'd0;
  localparam logic [2:0] REQ_FIND_ID       = 3'd1;
  localparam logic [2:0] REQ_FIND_CLASS    = 3'd2;
  localparam logic [2:0] REQ_FIND_CLASS_IF = 3'd3;
  localparam logic [2:0] REQ_CLEAR         = 3'd4;

  // A vendor field of all ones means that no function answered.
  localparam logic [15:0] VENDOR_NONE = 16'hFFFF;

  // Width of one stored class and location record.
  localparam int unsigned REC_W = 40;
  localparam int unsigned ID_W  = 32;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_NODEV = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP
  } state_e;

endpackage

/* sv/device_descriptor_table_search.sv */
// ----------------------------------------------------------------------------
// device_descriptor_table_search: table of discovered bus functions
// Appends bus functions to a table and finds the first one, in insertion
// order, that matches an identifier word or class keys.
// ----------------------------------------------------------------------------
// A request beat is taken when start_i is high while busy_o is low. Every
// request gives exactly one result beat, marked by done_o for a single
// cycle; the receiver cannot stall it, so it must take the beat in that
// cycle. Inserts, clears and unknown request codes start no scan: the
// result shows up in the cycle after the request and busy_o never rises. A
// lookup walks the stored entries one after another through a single shared
// comparator fed by the registered read port of the two entry memories, so
// each entry takes an address step and then a compare step. A lookup ends
// at the first hit or after the compare of the last stored entry, and a
// lookup in an empty table answers with a miss without a scan. While a
// lookup runs, busy_o is high; it drops in the cycle in which done_o is
// raised, so the next request may be given then. The memories need no
// clearing pass: only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module device_descriptor_table_search
  import ddts_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  bus_number_i,
  input  logic [4:0]  device_number_i,
  input  logic [2:0]  function_number_i,
  input  logic [31:0] id_word_i,
  input  logic [31:0] class_word_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [7:0]  entry_index_o,
  output logic [7:0]  found_bus_o,
  output logic [4:0]  found_device_o,
  output logic [2:0]  found_function_o
);

  // Index width addresses one entry; the count must also hold the depth.
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  // Sequencer and table state.
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   idx_q, idx_d;

  // Lookup request, held while the scan runs.
  logic [2:0]         req_q;
  logic [31:0]        key_id_q;
  logic [23:0]        key_cls_q;

  // Result beat registers.
  logic               done_q, done_d;
  status_e            status_q, status_d;
  logic [7:0]         index_q, index_d;
  logic [7:0]         bus_q, bus_d;
  logic [4:0]         dev_q, dev_d;
  logic [2:0]         fn_q, fn_d;

  // Memory ports.
  logic               ram_we;
  logic [REC_W-1:0]   rec_wdata;
  logic [ID_W-1:0]    id_rdata;
  logic [REC_W-1:0]   rec_rdata;

  logic               accept;
  logic               is_full;
  logic               no_dev;
  logic               hit;
  logic               last;

  assign accept  = start_i && (state_q == S_IDLE);
  assign is_full = (count_q == FULL_CNT);
  assign no_dev  = (id_word_i[15:0] == VENDOR_NONE);

  // Record layout: class, subclass, interface, bus, device, function.
  assign rec_wdata = {class_word_i[31:8], bus_number_i, device_number_i,
                      function_number_i};
  assign ram_we    = accept && (req_type_i == REQ_INSERT) && !no_dev && !is_full;

  ddts_ram #(
    .WIDTH (ID_W),
    .DEPTH (TABLE_DEPTH)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (id_word_i),
    .raddr_i (idx_q),
    .rdata_o (id_rdata)
  );

  ddts_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (rec_wdata),
    .raddr_i (idx_q),
    .rdata_o (rec_rdata)
  );

  // The shared comparator: one key compare chosen by the request code.
  always_comb begin
    unique case (req_q)
      REQ_FIND_ID:       hit = (id_rdata == key_id_q);
      REQ_FIND_CLASS:    hit = (rec_rdata[39:24] == key_cls_q[23:8]);
      REQ_FIND_CLASS_IF: hit = (rec_rdata[39:16] == key_cls_q);
      default:           hit = 1'b0;
    endcase
  end

  assign last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && count_q != '0 &&
            (req_type_i == REQ_FIND_ID || req_type_i == REQ_FIND_CLASS ||
             req_type_i == REQ_FIND_CLASS_IF)) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (hit || last) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs: scan index, table count and the result beat.
  always_comb begin
    idx_d    = idx_q;
    count_d  = count_q;
    done_d   = 1'b0;
    status_d = status_q;
    index_d  = index_q;
    bus_d    = bus_q;
    dev_d    = dev_q;
    fn_d     = fn_q;
    unique case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (accept) begin
          done_d   = 1'b1;
          status_d = ST_OK;
          index_d  = '0;
          bus_d    = '0;
          dev_d    = '0;
          fn_d     = '0;
          unique case (req_type_i)
            REQ_INSERT: begin
              if (no_dev) begin
                status_d = ST_NODEV;
              end else if (is_full) begin
                status_d = ST_FULL;
              end else begin
                index_d = 8'(count_q);
                bus_d   = bus_number_i;
                dev_d   = device_number_i;
                fn_d    = function_number_i;
                count_d = count_q + CNT_W'(1);
              end
            end
            REQ_FIND_ID, REQ_FIND_CLASS, REQ_FIND_CLASS_IF: begin
              // An empty table answers at once; otherwise the scan reports.
              if (count_q == '0) begin
                status_d = ST_MISS;
              end else begin
                done_d = 1'b0;
              end
            end
            REQ_CLEAR: begin
              count_d = '0;
            end
            default: begin
              status_d = ST_MISS;
            end
          endcase
        end
      end
      S_READ: begin
      end
      S_CMP: begin
        if (hit) begin
          done_d   = 1'b1;
          status_d = ST_OK;
          index_d  = 8'(idx_q);
          bus_d    = rec_rdata[15:8];
          dev_d    = rec_rdata[7:3];
          fn_d     = rec_rdata[2:0];
        end else if (last) begin
          done_d   = 1'b1;
          status_d = ST_MISS;
          index_d  = '0;
          bus_d    = '0;
          dev_d    = '0;
          fn_d     = '0;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    index_q  <= index_d;
    bus_q    <= bus_d;
    dev_q    <= dev_d;
    fn_q     <= fn_d;
    if (accept) begin
      req_q     <= req_type_i;
      key_id_q  <= id_word_i;
      key_cls_q <= class_word_i[31:8];
    end
  end

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign entry_index_o    = index_q;
  assign found_bus_o      = bus_q;
  assign found_device_o   = dev_q;
  assign found_function_o = fn_q;

`ifndef NO_ASSERTIONS
  // A result beat only follows an accepted request or a compare step.
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept || state_q == S_CMP))
    else $error("result beat without a request or compare step");

  // The fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("entry count beyond table depth");

  // A read step is always followed by its compare step.
  a_read_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> state_q == S_CMP)
    else $error("read step not followed by compare");

  // The scan never addresses an entry at or above the fill count.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> CNT_W'(idx_q) < count_q)
    else $error("scan index beyond stored entries");

  // A lookup in progress keeps the table count unchanged.
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> $stable(count_q))
    else $error("entry count changed during a lookup");
`endif

endmodule

/* sv/ddts_ram.sv */
// ----------------------------------------------------------------------------
// ddts_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module ddts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
